// ===== sv/i4dq_pkg.sv =====
// Package for the int4 pair dequantizer: binary16 constants and the
// integer-times-half multiply function. No dependencies.
`timescale 1ns / 1ps
package i4dq_pkg;
   localparam logic [15:0] HALF_EXP_MASK    = 16'h7C00;
   localparam logic [15:0] HALF_QUIET       = 16'h0200;
   localparam logic [15:0] HALF_DEFAULT_NAN = 16'h7E00;
   localparam int          NIBBLE_BITS      = 4;

   // Position of the leading one of a 14-bit product, plus one (0 for zero).
   function automatic logic [3:0] bit_len14(input logic [13:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 14; i++) begin
         if (v[i]) n = 4'(i + 1);
      end
      return n;
   endfunction

   // Signed 4-bit weight times binary16 scale, rounded to nearest even.
   function automatic logic [15:0] mul_nib_half(input logic [3:0] w, input logic [15:0] s);
      logic        sign;
      logic [4:0]  ef;
      logic [9:0]  frac;
      logic [3:0]  mag;
      logic [10:0] m;
      logic [13:0] p;
      logic [3:0]  len;
      logic signed [7:0] e, q, shift;
      logic [13:0] rem, half, mr;
      logic [11:0] r;
      logic signed [7:0] field;
      logic [15:0] res;
      sign = s[15] ^ w[3];
      ef   = s[14:10];
      frac = s[9:0];
      mag  = w[3] ? 4'(-w) : w;
      m    = (ef == 5'd0) ? {1'b0, frac} : {1'b1, frac};
      e    = (ef == 5'd0) ? -8'sd24 : $signed({3'b000, ef}) - 8'sd25;
      // A magnitude of at most eight times an 11-bit significand fits in 14 bits.
      p    = 14'(mag) * 14'(m);
      len  = bit_len14(p);
      q    = $signed({4'b0000, len}) - 8'sd11 + e;
      if (q < -8'sd24) q = -8'sd24;
      shift = q - e;
      r = 12'd0;
      res = 16'd0;
      if (shift <= 0) begin
         r = 12'(p << 4'(-shift));
      end else begin
         mr   = p >> 4'(shift);
         rem  = p & ((14'd1 << 4'(shift)) - 14'd1);
         half = 14'd1 << 4'(shift - 1);
         r = 12'(mr);
         if (rem > half || (rem == half && mr[0])) r = r + 12'd1;
      end
      if (r >= 12'd2048) begin
         r = r >> 1;
         q = q + 8'sd1;
      end
      field = q + 8'sd25;
      if (ef == 5'd31) begin
         if (frac != 10'd0) res = s | HALF_QUIET;
         else if (mag == 4'd0) res = HALF_DEFAULT_NAN;
         else res = {sign, 15'h7C00};
      end else if (p == 14'd0) begin
         res = {sign, 15'd0};
      end else if (r >= 12'd1024) begin
         if (field >= 8'sd31) res = {sign, 15'h7C00};
         else res = {sign, field[4:0], r[9:0]};
      end else begin
         res = {sign, 5'd0, r[9:0]};
      end
      return res;
   endfunction
endpackage

// ===== sv/int4_pair_dequant_fp16_core.sv =====
// Top level of the int4 pair dequantizer: input register, two lanes and a
// result register with stream handshakes. Depends on i4dq_pkg, i4dq_lane.
`timescale 1ns / 1ps
// Channel  Direction  tdata                                  tuser
// req      in         [7:0] packed_byte, [23:8] scale_bits   last_in (tlast)
// rsp      out        [15:0] low_half, [31:16] high_half     last_out (tlast)
// One transaction is accepted per cycle while the output is not stalled; a
// result passes through one register at the input and one at the output.
// Synchronous active-high reset clears only the valid flags.
// A stall reaches req_tready combinationally through both stages; each stage
// takes new data when it is empty or its own contents are leaving.
module int4_pair_dequant_fp16_core
   import i4dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // packed_byte, scale_bits
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // low_half, high_half
   output logic        rsp_tlast
);
   logic        in_vld_ff, in_vld_in, out_vld_ff, out_vld_in;
   logic [23:0] in_data_ff;
   logic        in_last_ff, out_last_ff;
   logic [31:0] out_data_ff, out_data_in;
   logic        adv_out, adv_in;

   // The result register loads when the input stage holds data and it is empty or being drained.
   assign adv_out    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv_out;
   assign adv_in     = req_tvalid && req_tready;
   assign in_vld_in  = adv_in || (in_vld_ff && !adv_out);
   assign out_vld_in = adv_out || (out_vld_ff && !rsp_tready);

   i4dq_lane u_lo (.nibble(in_data_ff[3:0]), .scale(in_data_ff[23:8]),
                   .product(out_data_in[15:0]));
   i4dq_lane u_hi (.nibble(in_data_ff[7:4]), .scale(in_data_ff[23:8]),
                   .product(out_data_in[31:16]));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (adv_in) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (adv_out) begin
         out_data_ff <= out_data_in;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_data_ff))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_tready) else $error("empty input stage not ready");
   a_move: assert property (@(posedge clock) disable iff (reset)
      adv_out |=> out_vld_ff) else $error("result lost");
endmodule

// ===== sv/i4dq_lane.sv =====
// One dequantizing lane: nibble times binary16 scale, combinational.
// Depends on i4dq_pkg.
`timescale 1ns / 1ps
module i4dq_lane
   import i4dq_pkg::*;
(
   input  logic [3:0]  nibble,
   input  logic [15:0] scale,
   output logic [15:0] product
);
   assign product = mul_nib_half(nibble, scale);
endmodule
